// File: rtl/link_target_switch_policy_macros.svh
// assertion macros for the link target switch policy block
// no dependencies; set NO_ASSERTIONS to compile them out
`ifndef LINK_TARGET_SWITCH_POLICY_MACROS_SVH
`define LINK_TARGET_SWITCH_POLICY_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lts assertion failed");
`define LTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lts assertion failed");
`else
`define LTS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/lts_pkg.sv
// types and codes shared by the link target switch policy block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lts_pkg;

    localparam int ADDR_W = 48;
    localparam int TYPE_W = 2;
    localparam int PEER_W = ADDR_W + TYPE_W;
    localparam int TIME_W = 32;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5000;

    typedef logic [2:0] t_kind;
    localparam t_kind KIND_SELECT       = 3'd0;
    localparam t_kind KIND_CLEAR        = 3'd1;
    localparam t_kind KIND_CONNECTED    = 3'd2;
    localparam t_kind KIND_DISCONNECTED = 3'd3;
    localparam t_kind KIND_TICK         = 3'd4;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_IDLE      = 2'd0;
    localparam t_mode MODE_SWITCHING = 2'd1;
    localparam t_mode MODE_CONNECTED = 2'd2;

    typedef logic [2:0] t_action;
    localparam t_action ACT_DISCONNECT   = 3'd0;
    localparam t_action ACT_START_ADV    = 3'd1;
    localparam t_action ACT_ACCEPT       = 3'd2;
    localparam t_action ACT_REJECT       = 3'd3;
    localparam t_action ACT_UI_SWITCHING = 3'd4;
    localparam t_action ACT_UI_CONNECTED = 3'd5;
    localparam t_action ACT_UI_ERROR     = 3'd6;
    localparam t_action ACT_UI_IDLE      = 3'd7;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ADDR_W-1:0] peer_address;
        logic [TYPE_W-1:0] peer_address_type;
        logic [TIME_W-1:0] now_ms;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] action;
        logic       last_action;
    } t_out_beat;

    typedef struct packed {
        t_mode             mode;
        logic [PEER_W-1:0] selected_peer;
        logic              selected_ok;
        logic [PEER_W-1:0] current_peer;
        logic              current_ok;
        logic [PEER_W-1:0] previous_peer;
        logic              previous_ok;
        logic [TIME_W-1:0] switch_start_time;
        logic              user_started;
    } t_state;

    typedef struct packed {
        t_state            state;
        t_action [2:0]     acts;
        logic [1:0]        count;
    } t_decision;

endpackage

`default_nettype wire

// File: rtl/lts_decide.sv
// per-event policy decision: next state and up to three actions
// depends on lts_pkg
`timescale 1ns / 1ps
`default_nettype none

module lts_decide
    import lts_pkg::*;
(
    input  wire t_in_beat                i_beat,
    input  wire t_state                  i_state,
    input  wire logic [TIME_W-1:0]       i_timeout,
    output t_decision                    o_dec
);

    logic [PEER_W-1:0] peer;
    logic [TIME_W-1:0] elapsed;
    logic              expired;

    assign peer    = {i_beat.peer_address_type, i_beat.peer_address};
    assign elapsed = i_beat.now_ms - i_state.switch_start_time;
    assign expired = !(elapsed < i_timeout);

    always_comb begin
        o_dec.state = i_state;
        o_dec.acts  = '{ACT_DISCONNECT, ACT_DISCONNECT, ACT_DISCONNECT};
        o_dec.count = 2'd0;
        unique case (i_beat.kind)
            KIND_SELECT: begin
                if (i_state.mode == MODE_CONNECTED && i_state.current_ok &&
                    i_state.current_peer == peer) begin
                    o_dec.state.selected_peer = peer;
                    o_dec.state.selected_ok   = 1'b1;
                    o_dec.acts[0]             = ACT_UI_CONNECTED;
                    o_dec.count               = 2'd1;
                end else begin
                    if (i_state.current_ok) begin
                        o_dec.state.previous_peer = i_state.current_peer;
                        o_dec.state.previous_ok   = 1'b1;
                    end
                    o_dec.state.selected_peer     = peer;
                    o_dec.state.selected_ok       = 1'b1;
                    o_dec.state.mode              = MODE_SWITCHING;
                    o_dec.state.switch_start_time = i_beat.now_ms;
                    o_dec.state.user_started      = 1'b1;
                    o_dec.acts[0]                 = ACT_DISCONNECT;
                    o_dec.acts[1]                 = ACT_START_ADV;
                    o_dec.acts[2]                 = ACT_UI_SWITCHING;
                    o_dec.count                   = 2'd3;
                end
            end
            KIND_CLEAR: begin
                o_dec.state.selected_ok = 1'b0;
                o_dec.state.previous_ok = 1'b0;
                o_dec.state.mode        = MODE_IDLE;
                o_dec.acts[0]           = ACT_UI_IDLE;
                o_dec.count             = 2'd1;
            end
            KIND_CONNECTED: begin
                if (i_state.mode == MODE_IDLE || !i_state.selected_ok) begin
                    o_dec.state.current_peer = peer;
                    o_dec.state.current_ok   = 1'b1;
                    o_dec.acts[0]            = ACT_ACCEPT;
                    o_dec.count              = 2'd1;
                end else if (i_state.selected_peer == peer) begin
                    o_dec.state.current_peer = peer;
                    o_dec.state.current_ok   = 1'b1;
                    o_dec.state.mode         = MODE_CONNECTED;
                    o_dec.state.previous_ok  = 1'b0;
                    o_dec.state.user_started = 1'b0;
                    o_dec.acts[0]            = ACT_ACCEPT;
                    o_dec.acts[1]            = ACT_UI_CONNECTED;
                    o_dec.count              = 2'd2;
                end else begin
                    o_dec.acts[0] = ACT_REJECT;
                    o_dec.count   = 2'd1;
                end
            end
            KIND_DISCONNECTED: begin
                o_dec.state.current_ok = 1'b0;
                if (i_state.current_ok && i_state.mode == MODE_CONNECTED) begin
                    o_dec.state.mode              = MODE_SWITCHING;
                    o_dec.state.switch_start_time = i_beat.now_ms;
                    o_dec.state.user_started      = 1'b0;
                    o_dec.acts[0]                 = ACT_START_ADV;
                    o_dec.acts[1]                 = ACT_UI_SWITCHING;
                    o_dec.count                   = 2'd2;
                end
            end
            KIND_TICK: begin
                if (i_state.mode == MODE_SWITCHING && i_state.user_started && expired) begin
                    o_dec.acts[0] = ACT_UI_ERROR;
                    o_dec.acts[1] = ACT_START_ADV;
                    o_dec.count   = 2'd3;
                    if (i_state.previous_ok) begin
                        o_dec.state.previous_ok       = 1'b0;
                        o_dec.state.selected_peer     = i_state.previous_peer;
                        o_dec.state.selected_ok       = 1'b1;
                        o_dec.state.switch_start_time = i_beat.now_ms;
                        o_dec.acts[2]                 = ACT_UI_SWITCHING;
                    end else begin
                        o_dec.state.selected_ok = 1'b0;
                        o_dec.state.mode        = MODE_IDLE;
                        o_dec.acts[2]           = ACT_UI_IDLE;
                    end
                end
            end
            default: begin
                o_dec.count = 2'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/link_target_switch_policy.sv
// path: an accepted input beat is registered, then its decided actions are registered in the action buffer
// throughput: one event per cycle while each yields at most one action and the receiver
//   does not stall; an event yielding more holds the single action buffer until its last action leaves
// reset: synchronous active low; state cleared, timeout back to 5000 ms, buffers empty
// depends on lts_pkg, lts_decide and link_target_switch_policy_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "link_target_switch_policy_macros.svh"

module link_target_switch_policy
    import lts_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_wr_en,
    input  wire logic [TIME_W-1:0] i_cfg_wr_data,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_beat         i_in_beat,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output t_out_beat             o_out_beat
);

    logic [TIME_W-1:0] r_timeout;
    logic              r_in_valid;
    t_in_beat          r_in_beat;
    t_state            r_state;
    t_action [2:0]     r_act;
    t_action [2:0]     n_act;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    t_decision         dec;
    logic              pop;
    logic              list_free;
    logic              advance;
    logic              load;
    logic              in_accept;

    lts_decide u_decide (
        .i_beat    (r_in_beat),
        .i_state   (r_state),
        .i_timeout (r_timeout),
        .o_dec     (dec)
    );

    assign o_out_valid            = (r_cnt != 2'd0);
    assign o_out_beat.action      = r_act[0];
    assign o_out_beat.last_action = (r_cnt == 2'd1);

    assign pop       = o_out_valid && !i_out_stall;
    assign list_free = (r_cnt == 2'd0) || (pop && r_cnt == 2'd1);
    assign advance   = r_in_valid && ((dec.count == 2'd0) || list_free);
    assign load      = advance && (dec.count != 2'd0);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        n_act = r_act;
        n_cnt = r_cnt;
        if (pop) begin
            n_act[0] = r_act[1];
            n_act[1] = r_act[2];
            n_cnt    = r_cnt - 2'd1;
        end
        if (load) begin
            n_act = dec.acts;
            n_cnt = dec.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RESET;
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_cnt      <= 2'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= dec.state;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_beat <= i_in_beat;
        end
        r_act <= n_act;
    end

    `LTS_ASSERT_NOW(a_connected_has_peer, i_clk, i_rst_n, r_state.mode == MODE_CONNECTED, r_state.current_ok)
    `LTS_ASSERT_NOW(a_active_has_target, i_clk, i_rst_n, r_state.mode != MODE_IDLE, r_state.selected_ok)
    `LTS_ASSERT_NEXT(a_blocked_beat_holds, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid && $stable(r_in_beat))

endmodule

`default_nettype wire

// File: dv/lts_action_checker.sv
// action checker for link_target_switch_policy: predicts the action beats of every
// accepted event beat and compares them with the beats that leave the block
// depends on lts_pkg
`timescale 1ns / 1ps

module lts_action_checker
    import lts_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_wr_en,
    input  wire [TIME_W-1:0]  i_cfg_wr_data,
    input  wire               i_in_valid,
    input  wire               i_in_stall,
    input  t_in_beat          i_in_beat,
    input  wire               i_out_valid,
    input  wire               i_out_stall,
    input  t_out_beat         i_out_beat,
    output int                o_fail_count,
    output int                o_pending
);

    t_state             policy;
    logic [TIME_W-1:0]  cfg_timeout;
    t_out_beat          expected_actions [$];
    int                 fails;

    function automatic void predict_actions(input t_in_beat b);
        logic [PEER_W-1:0] peer;
        logic [TIME_W-1:0] elapsed;
        t_action           acts [$];
        t_out_beat         o;
        logic              had_peer;
        peer = {b.peer_address_type, b.peer_address};
        case (b.kind)
            KIND_SELECT: begin
                if (policy.mode == MODE_CONNECTED && policy.current_ok
                        && policy.current_peer == peer) begin
                    policy.selected_peer = peer;
                    policy.selected_ok   = 1'b1;
                    acts.push_back(ACT_UI_CONNECTED);
                end else begin
                    if (policy.current_ok) begin
                        policy.previous_peer = policy.current_peer;
                        policy.previous_ok   = 1'b1;
                    end
                    policy.selected_peer     = peer;
                    policy.selected_ok       = 1'b1;
                    policy.mode              = MODE_SWITCHING;
                    policy.switch_start_time = b.now_ms;
                    policy.user_started      = 1'b1;
                    acts.push_back(ACT_DISCONNECT);
                    acts.push_back(ACT_START_ADV);
                    acts.push_back(ACT_UI_SWITCHING);
                end
            end
            KIND_CLEAR: begin
                policy.selected_ok = 1'b0;
                policy.previous_ok = 1'b0;
                policy.mode        = MODE_IDLE;
                acts.push_back(ACT_UI_IDLE);
            end
            KIND_CONNECTED: begin
                if (policy.mode == MODE_IDLE || !policy.selected_ok) begin
                    policy.current_peer = peer;
                    policy.current_ok   = 1'b1;
                    acts.push_back(ACT_ACCEPT);
                end else if (policy.selected_peer == peer) begin
                    policy.current_peer = peer;
                    policy.current_ok   = 1'b1;
                    policy.mode         = MODE_CONNECTED;
                    policy.previous_ok  = 1'b0;
                    policy.user_started = 1'b0;
                    acts.push_back(ACT_ACCEPT);
                    acts.push_back(ACT_UI_CONNECTED);
                end else begin
                    acts.push_back(ACT_REJECT);
                end
            end
            KIND_DISCONNECTED: begin
                had_peer = policy.current_ok;
                policy.current_ok = 1'b0;
                if (had_peer && policy.mode == MODE_CONNECTED) begin
                    policy.mode              = MODE_SWITCHING;
                    policy.switch_start_time = b.now_ms;
                    policy.user_started      = 1'b0;
                    acts.push_back(ACT_START_ADV);
                    acts.push_back(ACT_UI_SWITCHING);
                end
            end
            KIND_TICK: begin
                elapsed = b.now_ms - policy.switch_start_time;
                if (policy.mode == MODE_SWITCHING && policy.user_started
                        && elapsed >= cfg_timeout) begin
                    acts.push_back(ACT_UI_ERROR);
                    if (policy.previous_ok) begin
                        policy.previous_ok       = 1'b0;
                        policy.selected_peer     = policy.previous_peer;
                        policy.selected_ok       = 1'b1;
                        policy.switch_start_time = b.now_ms;
                        acts.push_back(ACT_START_ADV);
                        acts.push_back(ACT_UI_SWITCHING);
                    end else begin
                        policy.selected_ok = 1'b0;
                        policy.mode        = MODE_IDLE;
                        acts.push_back(ACT_START_ADV);
                        acts.push_back(ACT_UI_IDLE);
                    end
                end
            end
            default: ;
        endcase
        foreach (acts[i]) begin
            o.action      = acts[i];
            o.last_action = (i == acts.size() - 1);
            expected_actions.push_back(o);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_beat exp_beat;
        if (!i_rst_n) begin
            policy      = '0;
            policy.mode = MODE_IDLE;
            cfg_timeout = TIMEOUT_RESET;
            expected_actions.delete();
            fails       = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_actions.size() == 0) begin
                    $error("unexpected action beat: action %0d last_action %0d",
                           i_out_beat.action, i_out_beat.last_action);
                    fails++;
                end else begin
                    exp_beat = expected_actions.pop_front();
                    if (i_out_beat.action !== exp_beat.action) begin
                        $error("action mismatch: expected %0d, actual %0d",
                               exp_beat.action, i_out_beat.action);
                        fails++;
                    end
                    if (i_out_beat.last_action !== exp_beat.last_action) begin
                        $error("last_action mismatch: expected %0d, actual %0d",
                               exp_beat.last_action, i_out_beat.last_action);
                        fails++;
                    end
                end
            end
            if (i_cfg_wr_en)
                cfg_timeout = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall)
                predict_actions(i_in_beat);
        end
        o_fail_count <= fails;
        o_pending    <= expected_actions.size();
    end

endmodule

// File: dv/tb_link_target_switch_policy.sv
// testbench top for link_target_switch_policy: directed and random event beats,
// timeout register phases, bursty sender and stalling receiver, final verdict
// depends on lts_pkg, link_target_switch_policy and lts_action_checker
`timescale 1ns / 1ps

module tb_link_target_switch_policy;
    import lts_pkg::*;

    localparam int RUN_LIMIT = 200000;
    localparam int PHASE_EVENTS = 55;
    localparam t_kind KIND_SPARE_A = 3'd5;
    localparam t_kind KIND_SPARE_B = 3'd6;
    localparam t_kind KIND_SPARE_C = 3'd7;
    localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
    localparam logic [ADDR_W-1:0] ADDR_ZERO = '0;
    localparam logic [TIME_W-1:0] T_BASE = 32'hFFFF_F000;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [TIME_W-1:0]  cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    t_in_beat           in_beat;
    logic               out_valid;
    logic               out_stall;
    t_out_beat          out_beat;
    int                 fail_count;
    int                 pending;

    int                 burst_left;
    int                 gap_left;
    logic [TIME_W-1:0]  t_now;
    logic [TIME_W-1:0]  cur_timeout;
    logic [PEER_W-1:0]  peer_pool [4];
    logic [PEER_W-1:0]  last_sel;
    logic [TIME_W-1:0]  phase_timeouts [6];

    link_target_switch_policy dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_beat     (in_beat),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_beat    (out_beat)
    );

    lts_action_checker action_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_beat     (in_beat),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_beat    (out_beat),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ADDR_W-1:0];
    endfunction

    function automatic logic [TYPE_W-1:0] rand_type();
        logic [31:0] w;
        w = $urandom;
        return w[TYPE_W-1:0];
    endfunction

    function automatic t_in_beat make_event(input t_kind k, input logic [ADDR_W-1:0] a,
                                            input logic [TYPE_W-1:0] ty,
                                            input logic [TIME_W-1:0] t);
        t_in_beat b;
        b.kind              = k;
        b.peer_address      = a;
        b.peer_address_type = ty;
        b.now_ms            = t;
        return b;
    endfunction

    function automatic t_in_beat rand_event();
        t_in_beat          b;
        logic [PEER_W-1:0] p;
        logic [31:0]       w;
        int                r;
        r = $urandom_range(0, 99);
        w = $urandom;
        if (w[3:0] < 2)
            p = {rand_type(), rand_addr()};
        else if (w[4] && r >= 20 && r < 53)
            p = last_sel;
        else
            p = peer_pool[w[6:5]];
        case (w[10:8])
            3'd0: ;
            3'd1: t_now += $urandom_range(1, 10);
            3'd2: t_now += cur_timeout >> 2;
            3'd3: t_now += cur_timeout;
            3'd4: t_now += cur_timeout - 1;
            3'd5: t_now += cur_timeout + 1;
            3'd6: t_now += $urandom_range(0, 200);
            default: t_now = $urandom;
        endcase
        if (r < 20) begin
            b.kind   = KIND_SELECT;
            last_sel = p;
        end else if (r < 28) begin
            b.kind = KIND_CLEAR;
        end else if (r < 53) begin
            b.kind = KIND_CONNECTED;
        end else if (r < 68) begin
            b.kind = KIND_DISCONNECTED;
        end else if (r < 95) begin
            b.kind = KIND_TICK;
        end else begin
            b.kind = t_kind'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
        end
        b.peer_address      = p[ADDR_W-1:0];
        b.peer_address_type = p[PEER_W-1:ADDR_W];
        b.now_ms            = t_now;
        return b;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_event(input t_in_beat b);
        while (gap_left > 0) begin
            in_valid <= 1'b0;
            gap_left--;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
    endtask

    task automatic write_timeout(input logic [TIME_W-1:0] v);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        cur_timeout = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // receiver stall pattern: clear runs, light, medium and heavy stalling
    initial begin : out_stall_gen
        int style;
        int left;
        style = 0;
        left  = 0;
        forever begin
            @(negedge clk);
            if (left == 0) begin
                style = $urandom_range(0, 3);
                left  = $urandom_range(10, 150);
            end
            left--;
            case (style)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        in_beat     = '0;
        out_stall   = 1'b0;
        burst_left  = $urandom_range(1, 20);
        gap_left    = 0;
        cur_timeout = TIMEOUT_RESET;
        t_now       = T_BASE;
        phase_timeouts = '{32'd1, '1, $urandom, TIMEOUT_RESET,
                           $urandom_range(2, 50), 32'd0};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset timeout of 5000 ms, wrapping time, type compare
        send_event(make_event(KIND_SPARE_A, rand_addr(), rand_type(), $urandom));
        send_event(make_event(KIND_CONNECTED, ADDR_ONES, 2'd3, 32'd0));
        send_event(make_event(KIND_SELECT, ADDR_ONES, 2'd3, T_BASE));
        send_event(make_event(KIND_TICK, rand_addr(), rand_type(), T_BASE + 32'd4999));
        send_event(make_event(KIND_TICK, rand_addr(), rand_type(), T_BASE + 32'd5000));
        send_event(make_event(KIND_CONNECTED, ADDR_ZERO, 2'd0, $urandom));
        send_event(make_event(KIND_CONNECTED, ADDR_ONES, 2'd3, '1));
        send_event(make_event(KIND_SELECT, ADDR_ONES, 2'd3, 32'd0));
        send_event(make_event(KIND_DISCONNECTED, rand_addr(), rand_type(), '1));
        send_event(make_event(KIND_TICK, rand_addr(), rand_type(), 32'd0));
        send_event(make_event(KIND_CLEAR, rand_addr(), rand_type(), $urandom));
        send_event(make_event(KIND_CONNECTED, ADDR_ZERO, 2'd0, $urandom));
        send_event(make_event(KIND_SELECT, ADDR_ONES, 2'd1, 32'd100));
        send_event(make_event(KIND_CONNECTED, ADDR_ONES, 2'd3, $urandom));
        send_event(make_event(KIND_TICK, rand_addr(), rand_type(), 32'd5100));
        send_event(make_event(KIND_TICK, rand_addr(), rand_type(), 32'd10099));
        send_event(make_event(KIND_TICK, rand_addr(), rand_type(), 32'd10100));
        send_event(make_event(KIND_SPARE_B, rand_addr(), rand_type(), $urandom));
        send_event(make_event(KIND_SPARE_C, rand_addr(), rand_type(), $urandom));
        send_event(make_event(KIND_DISCONNECTED, rand_addr(), rand_type(), $urandom));
        // zero timeout expires on the first tick
        write_timeout(32'd0);
        send_event(make_event(KIND_SELECT, ADDR_ZERO, 2'd0, 32'd777));
        send_event(make_event(KIND_TICK, rand_addr(), rand_type(), 32'd777));

        foreach (phase_timeouts[ph]) begin
            write_timeout(phase_timeouts[ph]);
            foreach (peer_pool[i])
                peer_pool[i] = {rand_type(), rand_addr()};
            last_sel = peer_pool[0];
            repeat (PHASE_EVENTS) send_event(rand_event());
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
